>>> rtl/core/circular_deque_assert.svh
// Assertion macros shared by the circular deque RTL.
// Included by files that carry concurrent checks; needs no package.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Check a property on the rising clock, idle while reset is held low.
`define CDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock, also while reset is held.
`define CDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/cdq_pkg.sv
// Shared types and constants of the circular deque.
// No dependencies; imported by cdq_ring_mem, cdq_ctrl, circular_deque and the testbench.
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int OP_W        = 3;
  localparam int WORD_W      = 32;
  localparam int OCC_W       = 11;
  localparam int OUT_TDATA_W = 112;

  // opcodes; codes above OPC_QUERY behave as a query
  localparam logic [OP_W-1:0] OPC_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OPC_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OPC_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OPC_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OPC_QUERY      = 3'd4;

  localparam logic [WORD_W-1:0] NEG_ONE = '1;

  // result of one transaction, popped value in the lowest bits
  typedef struct packed {
    logic              rejected;
    logic              is_empty;
    logic [OCC_W-1:0]  occupancy;
    logic [WORD_W-1:0] back_value;
    logic [WORD_W-1:0] front_value;
    logic [WORD_W-1:0] popped_value;
  } cdq_result_t;

  // controller status seen by the top level
  typedef struct packed {
    logic filling;
    logic empty;
  } cdq_status_t;

endpackage

>>> rtl/core/cdq_ring_mem.sv
// Ring store of the circular deque: one write port, one registered read port.
// Depends on cdq_pkg for the word width.
`timescale 1ns / 1ps

module cdq_ring_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [cdq_pkg::WORD_W-1:0]               wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [cdq_pkg::WORD_W-1:0]               rd_data
);
  import cdq_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  // write one word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_q[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/cdq_ctrl.sv
// Deque controller: head, tail and count, cached end words, ring store access.
// Depends on cdq_pkg; drives cdq_ring_mem from the top level.
`timescale 1ns / 1ps

module cdq_ctrl #(
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  input  logic [cdq_pkg::OP_W-1:0]                 in_opcode,
  input  logic [cdq_pkg::WORD_W-1:0]               in_value,
  input  logic                                     out_free,
  output logic                                     in_ready,
  output logic                                     res_valid,
  output cdq_pkg::cdq_result_t                     res,
  output cdq_pkg::cdq_status_t                     status,
  output logic                                     wr_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  output logic [cdq_pkg::WORD_W-1:0]               wr_data,
  output logic                                     rd_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  logic [cdq_pkg::WORD_W-1:0]               rd_data
);
  import cdq_pkg::*;

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_FILL = 1'b1;

  logic              state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [WORD_W-1:0] front_r, front_nxt;
  logic [WORD_W-1:0] back_r, back_nxt;
  cdq_result_t       res_r;
  logic              fill_front_r;

  logic              accept;
  logic              full;
  logic              empty;
  logic              need_fill;
  logic              fill_front;
  logic [WORD_W-1:0] popped;
  logic              rej;
  cdq_result_t       res_now;
  cdq_result_t       res_fill;

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_W'(DEPTH - 1) : s - SLOT_W'(1);
  endfunction

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // decode one transaction against the current pointers and cached ends
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    wr_data    = in_value;
    rd_en      = 1'b0;
    rd_addr    = slot_next(slot_next(head_r));
    popped     = '0;
    rej        = 1'b0;
    need_fill  = 1'b0;
    fill_front = 1'b0;
    if (accept) begin
      case (in_opcode)
        OPC_PUSH_FRONT: begin
          if (full) begin
            rej = 1'b1;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = head_r;
            head_nxt  = slot_prev(head_r);
            count_nxt = count_r + CNT_W'(1);
            front_nxt = in_value;
            if (empty) begin
              back_nxt = in_value;
            end
          end
        end
        OPC_PUSH_BACK: begin
          if (full) begin
            rej = 1'b1;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = slot_next(tail_r);
            tail_nxt  = slot_next(tail_r);
            count_nxt = count_r + CNT_W'(1);
            back_nxt  = in_value;
            if (empty) begin
              front_nxt = in_value;
            end
          end
        end
        OPC_POP_FRONT: begin
          if (empty) begin
            popped = NEG_ONE;
            rej    = 1'b1;
          end else begin
            popped    = front_r;
            head_nxt  = slot_next(head_r);
            count_nxt = count_r - CNT_W'(1);
            if (count_r == CNT_W'(2)) begin
              front_nxt = back_r;
            end else if (count_r > CNT_W'(2)) begin
              // new first element lies two slots past the old head
              rd_en      = 1'b1;
              rd_addr    = slot_next(slot_next(head_r));
              need_fill  = 1'b1;
              fill_front = 1'b1;
            end
          end
        end
        OPC_POP_BACK: begin
          if (empty) begin
            popped = NEG_ONE;
            rej    = 1'b1;
          end else begin
            popped    = back_r;
            tail_nxt  = slot_prev(tail_r);
            count_nxt = count_r - CNT_W'(1);
            if (count_r == CNT_W'(2)) begin
              back_nxt = front_r;
            end else if (count_r > CNT_W'(2)) begin
              rd_en     = 1'b1;
              rd_addr   = slot_prev(tail_r);
              need_fill = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // assemble the result of this transaction
  always_comb begin
    res_now.popped_value = popped;
    res_now.front_value  = (count_nxt == '0) ? NEG_ONE : front_nxt;
    res_now.back_value   = (count_nxt == '0) ? NEG_ONE : back_nxt;
    res_now.occupancy    = OCC_W'(count_nxt);
    res_now.is_empty     = (count_nxt == '0);
    res_now.rejected     = rej;
  end

  // patch the staged result with the word read from the ring store
  always_comb begin
    res_fill = res_r;
    if (fill_front_r) begin
      res_fill.front_value = rd_data;
    end else begin
      res_fill.back_value = rd_data;
    end
  end

  assign res_valid = (accept && !need_fill) || (state_r == S_FILL);
  assign res       = (state_r == S_FILL) ? res_fill : res_now;

  assign status.filling = (state_r == S_FILL);
  assign status.empty   = empty;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && need_fill) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // cached end words and the staged result
  always_ff @(posedge clk) begin
    if (state_r == S_FILL) begin
      if (fill_front_r) begin
        front_r <= rd_data;
      end else begin
        back_r <= rd_data;
      end
    end else begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
    end
    if (accept && need_fill) begin
      res_r        <= res_now;
      fill_front_r <= fill_front;
    end
  end

endmodule

>>> rtl/core/circular_deque.sv
// Circular deque top level: stream ports, output register, checks.
// Depends on cdq_pkg, cdq_ring_mem, cdq_ctrl and circular_deque_assert.svh.
`timescale 1ns / 1ps
`include "circular_deque_assert.svh"

// Double-ended queue of signed 32-bit words kept in a DEPTH-entry ring store.
// Each input transaction carries an opcode (push front, push back, pop front,
// pop back, query; unused codes act as query) and returns exactly one result
// with the popped word, the first and last words, the occupancy and the empty
// and rejected flags. The first and last words are held in registers, so
// pushes, queries, rejected operations and pops that leave at most one word
// behind need no store read. A pop that leaves two or more words stalls the
// input in a fill state while the new end word comes from the ring store's
// registered read port. A result is registered; the next transaction
// is taken in the same cycle the waiting result is taken. No clearing pass
// runs after reset; entries are read only once written.
module circular_deque #(
  parameter int DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,  // [31:0] push_value
  input  logic [cdq_pkg::OP_W-1:0]           in_tuser,  // [2:0] opcode
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] popped_value, [63:32] front_value, [95:64] back_value,
  // [106:96] occupancy, [107] is_empty, [108] rejected, [111:109] zero
  output logic [cdq_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import cdq_pkg::*;

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RES_W  = $bits(cdq_result_t);

  logic              out_valid_r;
  cdq_result_t       out_data_r;
  logic              out_free;
  logic              res_valid;
  cdq_result_t       res;
  cdq_status_t       status;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;

  assign out_free = !out_valid_r || out_tready;

  cdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_opcode(in_tuser),
    .in_value (in_tdata),
    .out_free (out_free),
    .in_ready (in_tready),
    .res_valid(res_valid),
    .res      (res),
    .status   (status),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  cdq_ring_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // hold a result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_data_r};

  // a store read is pending only while the output register is free
  `CDQ_ASSERT(a_fill_out_free, clk, rst_n, status.filling |-> !out_valid_r, "fill with result waiting")
  // the result is offered in the cycle after the fill state, which then ends
  `CDQ_ASSERT(a_fill_delivers, clk, rst_n, status.filling |=> out_valid_r && !status.filling, "fill not delivered")
  // a pop from an empty deque comes back rejected
  `CDQ_ASSERT(a_empty_pop_rej, clk, rst_n, in_tvalid && in_tready && status.empty && (in_tuser == OPC_POP_FRONT || in_tuser == OPC_POP_BACK) |=> out_tvalid && out_tdata[108], "empty pop not rejected")
  // nothing is offered downstream during reset
  `CDQ_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid, "result offered after reset")

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the circular deque: directed corner cases, then random streams.
// Depends on cdq_pkg and circular_deque; drives both stream ports with random idle gaps.
`timescale 1ns / 1ps

module testbench;
  import cdq_pkg::*;

  localparam int RING_DEPTH   = 1024;
  localparam int IDX_W        = $clog2(RING_DEPTH);
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  // spare opcodes, treated as a query by the block
  localparam logic [OP_W-1:0] OPC_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OPC_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OPC_SPARE_7 = 3'd7;

  // Mirror of the deque contents and the queue of results still owed by the block
  class deque_scoreboard;
    logic [WORD_W-1:0] slots [RING_DEPTH];
    logic [IDX_W-1:0]  front_gap;
    logic [IDX_W-1:0]  last_slot;
    int                fill_level;
    int                errors;
    cdq_result_t       expected_results [$];

    function new();
      front_gap  = '0;
      last_slot  = '0;
      fill_level = 0;
      errors     = 0;
    endfunction

    function int level();
      return fill_level;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Apply one accepted transaction and queue the result it must produce
    function void note_transaction(logic [OP_W-1:0] op, logic [WORD_W-1:0] word);
      cdq_result_t      res;
      logic [IDX_W-1:0] first;
      bit               full;
      bit               empty;
      res   = '0;
      full  = (fill_level >= RING_DEPTH);
      empty = (fill_level == 0);
      case (op)
        OPC_PUSH_FRONT: begin
          if (full) begin
            res.rejected = 1'b1;
          end else begin
            slots[front_gap] = word;
            front_gap = front_gap - IDX_W'(1);
            fill_level++;
          end
        end
        OPC_PUSH_BACK: begin
          if (full) begin
            res.rejected = 1'b1;
          end else begin
            last_slot = last_slot + IDX_W'(1);
            slots[last_slot] = word;
            fill_level++;
          end
        end
        OPC_POP_FRONT: begin
          if (empty) begin
            res.popped_value = NEG_ONE;
            res.rejected = 1'b1;
          end else begin
            front_gap = front_gap + IDX_W'(1);
            res.popped_value = slots[front_gap];
            fill_level--;
          end
        end
        OPC_POP_BACK: begin
          if (empty) begin
            res.popped_value = NEG_ONE;
            res.rejected = 1'b1;
          end else begin
            res.popped_value = slots[last_slot];
            last_slot = last_slot - IDX_W'(1);
            fill_level--;
          end
        end
        default: begin
        end
      endcase
      // report both ends after the update
      first = front_gap + IDX_W'(1);
      if (fill_level == 0) begin
        res.front_value = NEG_ONE;
        res.back_value  = NEG_ONE;
        res.is_empty    = 1'b1;
      end else begin
        res.front_value = slots[first];
        res.back_value  = slots[last_slot];
      end
      res.occupancy = fill_level[OCC_W-1:0];
      expected_results.insert(expected_results.size(), res);
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Check one accepted result against the oldest expectation
    function void check_result(cdq_result_t got);
      cdq_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      compare_field("popped_value", want.popped_value, got.popped_value);
      compare_field("front_value", want.front_value, got.front_value);
      compare_field("back_value", want.back_value, got.back_value);
      compare_field("occupancy", want.occupancy, got.occupancy);
      compare_field("is_empty", want.is_empty, got.is_empty);
      compare_field("rejected", want.rejected, got.rejected);
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [31:0]            in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  deque_scoreboard sb;
  int              stall_cycles;
  int              calm_in;
  int              calm_out;

  circular_deque #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Idle cycles before the next transaction; calm stretches have none
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // Mostly random words, with the signed extremes mixed in
  function automatic logic [WORD_W-1:0] draw_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Present one transaction at the falling edge and hold it until accepted
  task automatic issue_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word);
    int gap;
    gap = draw_gap(calm_in);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [OP_W-1:0] pick_push();
    return $urandom_range(0, 1) ? OPC_PUSH_BACK : OPC_PUSH_FRONT;
  endfunction

  function automatic logic [OP_W-1:0] pick_pop();
    return $urandom_range(0, 1) ? OPC_POP_BACK : OPC_POP_FRONT;
  endfunction

  // Random mix of pushes, pops and queries, spare opcodes included
  task automatic run_mix(input int items, input int push_pct);
    int pick;
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
        issue_op(pick_push(), draw_word());
      end else if (pick < 92) begin
        issue_op(pick_pop(), draw_word());
      end else begin
        issue_op(OP_W'($urandom_range(OPC_QUERY, OPC_SPARE_7)), draw_word());
      end
    end
  endtask

  // Accept results with random stalls
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_gap(calm_out);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_transaction(in_tuser, in_tdata);
      end
      if (out_tvalid && out_tready) begin
        sb.check_result(cdq_result_t'(out_tdata[$bits(cdq_result_t)-1:0]));
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // End the run if traffic stops
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    sb           = new();
    stall_cycles = 0;
    calm_in      = 0;
    calm_out     = 0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OPC_QUERY;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pops and queries on an empty deque
    issue_op(OPC_POP_FRONT, 32'h1234_5678);
    issue_op(OPC_POP_BACK, 32'h8765_4321);
    issue_op(OPC_QUERY, '1);
    issue_op(OPC_SPARE_5, '0);
    issue_op(OPC_SPARE_6, 32'h5555_5555);
    // extremes at both ends
    issue_op(OPC_PUSH_FRONT, 32'h7FFF_FFFF);
    issue_op(OPC_PUSH_BACK, 32'h8000_0000);
    issue_op(OPC_PUSH_FRONT, '0);
    issue_op(OPC_PUSH_BACK, '1);
    issue_op(OPC_PUSH_FRONT, 32'h0000_0001);
    issue_op(OPC_QUERY, 32'hAAAA_AAAA);
    issue_op(OPC_POP_FRONT, '0);
    issue_op(OPC_POP_BACK, '0);
    issue_op(OPC_POP_BACK, '0);
    issue_op(OPC_POP_FRONT, '0);
    issue_op(OPC_SPARE_7, '1);
    issue_op(OPC_POP_BACK, '0);
    issue_op(OPC_POP_FRONT, '0);
    issue_op(OPC_PUSH_BACK, 32'hA5A5_A5A5);
    issue_op(OPC_POP_FRONT, '0);
    issue_op(OPC_PUSH_FRONT, 32'h5A5A_5A5A);
    issue_op(OPC_POP_BACK, '0);

    // random traffic, then fill to full, probe, and mix again with pops favored
    run_mix(100, 50);
    while (sb.level() < RING_DEPTH) begin
      issue_op(pick_push(), draw_word());
    end
    run_mix(30, 55);
    run_mix(150, 20);
    in_tvalid <= 1'b0;

    // wait for the remaining results, then let the pipeline settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
